[sv/crmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle row mask rasteriser package
// Shared widths, types and defaults for the circle row mask rasteriser.
// ----------------------------------------------------------------------------
package crmr_pkg;

    localparam int MAX_RADIUS_DEF = 32;
    localparam int RADIUS_W       = 6;
    localparam int ROW_IDX_W      = 6;
    localparam int CENTER_W       = 15;
    localparam int COORD_W        = 16;
    localparam int MASK_W         = 64;
    localparam int COLOR_W        = 32;
    localparam int SQ_W           = 11;
    localparam int LANE_SQ_W      = 13;
    localparam int DIST_W         = 14;

    typedef logic signed [CENTER_W-1:0] t_center;
    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic [RADIUS_W-1:0]        t_radius;
    typedef logic [ROW_IDX_W-1:0]       t_row_idx;
    typedef logic [COLOR_W-1:0]         t_color;
    typedef logic [SQ_W-1:0]            t_sq;
    typedef logic [LANE_SQ_W-1:0]       t_lane_sq;
    typedef logic [DIST_W-1:0]          t_dist;

endpackage

[sv/circle_row_mask_rasterizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle row mask rasteriser
// Turns one circle request into one lit-pixel mask per scanned row.
// ----------------------------------------------------------------------------
// A request (centre, radius, outline or filled mode, colour) is taken on the
// input channel; the block then returns 2r rows from the top row down, or
// one empty row for a zero radius, each with its y, the x of mask bit 0, the
// mask, the colour and a last-row flag. Radii above MAX_RADIUS are clamped.
// A row sequencer issues one row per cycle into a three-stage pipeline
// (row offset, squares and bounds, per-pixel distance test into the output
// register). A request's first row passes the holding registers, stage 1
// and stage 2 before it reaches the output register. The sequencer holds
// one request at a time, so o_in_ready stays low until its last row is
// issued; the next request is taken while earlier rows are still in the
// pipeline. When the receiver stalls, the whole pipeline and the sequencer
// hold in place and nothing is lost. Reset is synchronous and active low;
// it empties the pipeline and leaves the block ready for a request.
// ----------------------------------------------------------------------------
module circle_row_mask_rasterizer_unit
    import crmr_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [14:0]  i_center_x,
    input  logic signed [14:0]  i_center_y,
    input  logic [5:0]          i_radius,
    input  logic                i_filled,
    input  logic [31:0]         i_color_rgba,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_row_y,
    output logic signed [15:0]  o_start_x,
    output logic [63:0]         o_row_mask,
    output logic [31:0]         o_pixel_color,
    output logic                o_last_row
);

    localparam int LANES = 2 * MAX_RADIUS;

    logic     w_en;
    t_radius  w_radius_sat;

    logic     r_busy;
    t_row_idx r_row_idx;
    t_row_idx r_last_idx;
    t_center  r_hold_cx;
    t_center  r_hold_cy;
    t_radius  r_hold_r;
    logic     r_hold_filled;
    t_color   r_hold_color;

    logic                r_s1_v;
    logic signed [6:0]   r_s1_dy;
    t_radius             r_s1_r;
    logic                r_s1_filled;
    t_center             r_s1_cx;
    t_center             r_s1_cy;
    t_color              r_s1_color;
    logic                r_s1_last;

    logic signed [13:0]  w_dy_sq;
    logic [11:0]         w_r_sq;
    logic signed [7:0]   w_dx [LANES];
    logic signed [15:0]  w_dx_sq [LANES];
    t_sq                 n_s2_lo;
    t_sq                 n_s2_hi;
    t_lane_sq            n_s2_dx2 [LANES];
    logic [LANES-1:0]    n_s2_on;

    logic                r_s2_v;
    t_sq                 r_s2_dy2;
    t_sq                 r_s2_lo;
    t_sq                 r_s2_hi;
    t_lane_sq            r_s2_dx2 [LANES];
    logic [LANES-1:0]    r_s2_on;
    t_coord              r_s2_row_y;
    t_coord              r_s2_start_x;
    t_color              r_s2_color;
    logic                r_s2_last;

    t_dist               w_dist [LANES];
    logic [LANES-1:0]    n_s3_mask;

    logic                r_s3_v;
    logic [LANES-1:0]    r_s3_mask;
    t_coord              r_s3_row_y;
    t_coord              r_s3_start_x;
    t_color              r_s3_color;
    logic                r_s3_last;

    assign w_en       = !r_s3_v || i_out_ready;
    assign o_in_ready = !r_busy;

    assign w_radius_sat = (i_radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : i_radius;

    // Row sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_row_idx <= '0;
        end else if (i_in_valid && o_in_ready) begin
            r_busy    <= 1'b1;
            r_row_idx <= '0;
        end else if (r_busy && w_en) begin
            r_row_idx <= r_row_idx + ROW_IDX_W'(1);
            if (r_row_idx == r_last_idx) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_hold_cx     <= i_center_x;
            r_hold_cy     <= i_center_y;
            r_hold_r      <= w_radius_sat;
            r_hold_filled <= i_filled;
            r_hold_color  <= i_color_rgba;
            r_last_idx    <= (w_radius_sat == '0) ? '0
                             : ROW_IDX_W'({w_radius_sat, 1'b0} - 7'd1);
        end
    end

    // Stage 1: row offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_busy) begin
            r_s1_dy     <= $signed({1'b0, r_hold_r}) - $signed({1'b0, r_row_idx});
            r_s1_r      <= r_hold_r;
            r_s1_filled <= r_hold_filled;
            r_s1_cx     <= r_hold_cx;
            r_s1_cy     <= r_hold_cy;
            r_s1_color  <= r_hold_color;
            r_s1_last   <= (r_row_idx == r_last_idx);
        end
    end

    // Stage 2: squares, bounds and coordinates.
    always_comb begin
        w_dy_sq = 14'(r_s1_dy) * 14'(r_s1_dy);
        w_r_sq  = 12'(r_s1_r) * 12'(r_s1_r);
        if (r_s1_filled) begin
            n_s2_lo = '0;
            n_s2_hi = SQ_W'(w_r_sq);
        end else begin
            n_s2_lo = SQ_W'(w_r_sq - 12'(r_s1_r));
            n_s2_hi = SQ_W'(w_r_sq + 12'(r_s1_r));
        end
        for (int i = 0; i < LANES; i++) begin
            w_dx[i]     = 8'(i + 1) - $signed({2'b00, r_s1_r});
            w_dx_sq[i]  = 16'(w_dx[i]) * 16'(w_dx[i]);
            n_s2_dx2[i] = w_dx_sq[i][LANE_SQ_W-1:0];
            n_s2_on[i]  = (7'(i) < {r_s1_r, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_v) begin
            r_s2_dy2     <= w_dy_sq[SQ_W-1:0];
            r_s2_lo      <= n_s2_lo;
            r_s2_hi      <= n_s2_hi;
            r_s2_dx2     <= n_s2_dx2;
            r_s2_on      <= n_s2_on;
            r_s2_row_y   <= COORD_W'(r_s1_cy) + COORD_W'(r_s1_dy);
            r_s2_start_x <= COORD_W'(r_s1_cx) - $signed(COORD_W'(r_s1_r)) + 16'sd1;
            r_s2_color   <= r_s1_color;
            r_s2_last    <= r_s1_last;
        end
    end

    // Stage 3: per-pixel distance test.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_dist[i]    = DIST_W'(r_s2_dx2[i]) + DIST_W'(r_s2_dy2);
            n_s3_mask[i] = r_s2_on[i] && (w_dist[i] >= DIST_W'(r_s2_lo))
                           && (w_dist[i] <= DIST_W'(r_s2_hi));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s2_v) begin
            r_s3_mask    <= n_s3_mask;
            r_s3_row_y   <= r_s2_row_y;
            r_s3_start_x <= r_s2_start_x;
            r_s3_color   <= r_s2_color;
            r_s3_last    <= r_s2_last;
        end
    end

    assign o_out_valid   = r_s3_v;
    assign o_row_y       = r_s3_row_y;
    assign o_start_x     = r_s3_start_x;
    assign o_row_mask    = MASK_W'(r_s3_mask);
    assign o_pixel_color = r_s3_color;
    assign o_last_row    = r_s3_last;

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_busy && r_row_idx == '0))
        else $error("Accepted request did not start the row sequencer.");

    a_row_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_row_idx <= r_last_idx))
        else $error("Row index ran past the final row.");

    a_last_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_en && r_row_idx == r_last_idx) |=> (r_s1_v && r_s1_last && !r_busy))
        else $error("Final row was not issued with its last flag.");

endmodule
